// ===== hw/rtl/pnc_pkg.sv =====
package pnc_pkg;

  localparam int unsigned PaletteSize = 16;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned NumSlots    = 2 ** IdxW;
  localparam int unsigned NumRegs     = (NumSlots + 1) / 2;
  localparam int unsigned RegIdxW     = $clog2(NumRegs);
  localparam int unsigned RegW        = 32;
  localparam int unsigned ColorW      = 16;
  localparam int unsigned CompW       = 8;
  localparam int unsigned DistW       = 10;

  typedef logic [ColorW-1:0] color_t;
  typedef logic [CompW-1:0]  comp_t;
  typedef logic [DistW-1:0]  dist_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [RegW-1:0]   reg_t;

  typedef struct packed {
    dist_t cost;
    idx_t  idx;
  } cand_t;

  localparam dist_t DistPad = '1;

  localparam reg_t PalReset [NumRegs] = '{
    32'hFFFF0000, 32'hF8008410, 32'h001F07E0, 32'h07FFFFE0,
    32'h8000F81F, 32'h00100400, 32'h000739E7, 32'h00000000
  };

  function automatic comp_t comp_r(color_t c);
    return {c[15:11], 3'b000};
  endfunction

  function automatic comp_t comp_g(color_t c);
    return {c[10:5], 2'b00};
  endfunction

  function automatic comp_t comp_b(color_t c);
    return {c[4:0], 3'b000};
  endfunction

  function automatic comp_t absdiff(comp_t a, comp_t b);
    return (a > b) ? comp_t'(a - b) : comp_t'(b - a);
  endfunction

  function automatic dist_t manhattan(color_t p, color_t e);
    return dist_t'(absdiff(comp_r(p), comp_r(e)))
         + dist_t'(absdiff(comp_g(p), comp_g(e)))
         + dist_t'(absdiff(comp_b(p), comp_b(e)));
  endfunction

  // lower index wins a tie: a always carries the lower index
  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.cost < a.cost) ? b : a;
  endfunction

endpackage

// ===== hw/rtl/palette_nearest_color_packer_top.sv =====
// Maps each pair of RGB565 pixels to the nearest colors of a 16-entry RGB565 palette
// by Manhattan distance over 8-bit widened components (lowest index wins a tie) and
// returns one byte per item: first pixel's index in bits 7..4, second's in bits 3..0.
// One item is taken every cycle while the output is drained; each item is registered first
// in the 16 distance lanes, then in the mid and final levels of the registered minimum
// tree. A stalled output holds the whole pipeline. The palette sits in eight
// 32-bit registers, entry 2k in the low half of register k; write them while idle.
module palette_nearest_color_packer_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [31:0]             s_axis_tdata,  // first_pixel, second_pixel
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,  // packed_indices
  input  logic                    cfg_we_i,
  input  logic [pnc_pkg::RegIdxW-1:0] cfg_idx_i,
  input  pnc_pkg::reg_t           cfg_wdata_i
);
  import pnc_pkg::*;

  localparam int unsigned Stages = 3;

  reg_t             pal_q [NumRegs];
  logic [Stages-1:0] vld_q, vld_d;
  logic             adv;
  color_t           pix_a, pix_b;
  dist_t            dist_a [NumSlots];
  dist_t            dist_b [NumSlots];
  idx_t             idx_a, idx_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= PalReset;
    end else if (cfg_we_i) begin
      pal_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign adv   = !vld_q[Stages-1] || m_axis_tready;
  assign vld_d = {vld_q[Stages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  assign pix_a = s_axis_tdata[ColorW-1:0];
  assign pix_b = s_axis_tdata[2*ColorW-1:ColorW];

  for (genvar i = 0; i < NumSlots; i++) begin : g_lane
    if (i < PaletteSize) begin : g_used
      pnc_lane u_lane (
        .clk_i    (clk_i),
        .en_i     (adv),
        .pix_a_i  (pix_a),
        .pix_b_i  (pix_b),
        .entry_i  (pal_q[i/2][(i%2)*ColorW +: ColorW]),
        .dist_a_o (dist_a[i]),
        .dist_b_o (dist_b[i])
      );
    end else begin : g_pad
      assign dist_a[i] = DistPad;
      assign dist_b[i] = DistPad;
    end
  end

  pnc_merge u_merge_a (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dist_i (dist_a),
    .idx_o  (idx_a)
  );

  pnc_merge u_merge_b (
    .clk_i  (clk_i),
    .en_i   (adv),
    .dist_i (dist_b),
    .idx_o  (idx_b)
  );

  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Stages-1];
  assign m_axis_tdata  = {idx_a, idx_b};

endmodule

// ===== hw/rtl/pnc_lane.sv =====
module pnc_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  pnc_pkg::color_t pix_a_i,
  input  pnc_pkg::color_t pix_b_i,
  input  pnc_pkg::color_t entry_i,
  output pnc_pkg::dist_t  dist_a_o,
  output pnc_pkg::dist_t  dist_b_o
);
  import pnc_pkg::*;

  dist_t dist_a_q, dist_a_d;
  dist_t dist_b_q, dist_b_d;

  assign dist_a_d = manhattan(pix_a_i, entry_i);
  assign dist_b_d = manhattan(pix_b_i, entry_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_a_q <= dist_a_d;
      dist_b_q <= dist_b_d;
    end
  end

  assign dist_a_o = dist_a_q;
  assign dist_b_o = dist_b_q;

endmodule

// ===== hw/rtl/pnc_merge.sv =====
module pnc_merge (
  input  logic           clk_i,
  input  logic           en_i,
  input  pnc_pkg::dist_t dist_i [pnc_pkg::NumSlots],
  output pnc_pkg::idx_t  idx_o
);
  import pnc_pkg::*;

  localparam int unsigned NumMid = NumSlots / 4;

  cand_t mid_q [NumMid];
  cand_t mid_d [NumMid];
  idx_t  idx_q, idx_d;

  always_comb begin
    cand_t c0, c1, c2, c3;
    for (int m = 0; m < NumMid; m++) begin
      c0 = '{cost: dist_i[4*m],   idx: idx_t'(4*m)};
      c1 = '{cost: dist_i[4*m+1], idx: idx_t'(4*m+1)};
      c2 = '{cost: dist_i[4*m+2], idx: idx_t'(4*m+2)};
      c3 = '{cost: dist_i[4*m+3], idx: idx_t'(4*m+3)};
      mid_d[m] = pick(pick(c0, c1), pick(c2, c3));
    end
  end

  always_comb begin
    cand_t best;
    best = mid_q[0];
    for (int m = 1; m < NumMid; m++) begin
      best = pick(best, mid_q[m]);
    end
    idx_d = best.idx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
      idx_q <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

// ===== hw/rtl/pnc_checker.sv =====
module pnc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [7:0]                    m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("item lost in pipeline");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind palette_nearest_color_packer_top pnc_checker u_pnc_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pnc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PipeDepth  = 3;
  localparam int unsigned RandPhases = 6;
  localparam int unsigned PhaseItems = 320;

  typedef enum int unsigned {
    StallNone,
    StallRandom,
    StallDuty,
    StallRuns
  } stall_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;  // first_pixel, second_pixel
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;        // packed_indices
  logic               cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i     = '0;
  reg_t               cfg_wdata_i   = '0;

  reg_t        palette_q [NumRegs];
  logic [7:0]  expected_bytes_q [$];
  logic [7:0]  want_byte;
  int unsigned pairs_sent      = 0;
  int unsigned bytes_checked   = 0;
  int unsigned mismatches      = 0;
  int unsigned palettes_loaded = 0;
  int unsigned cycle_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned stall_hold      = 0;
  stall_e      stall_mode      = StallNone;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  palette_nearest_color_packer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic int chan_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic color_t palette_color(int unsigned slot);
    reg_t word;
    word = palette_q[slot / 2];
    return (slot % 2) ? word[31:16] : word[15:0];
  endfunction

  function automatic idx_t closest_entry(color_t pix);
    idx_t   best;
    int     best_d;
    int     d;
    color_t e;
    best   = '0;
    best_d = 1 << 20;
    for (int unsigned slot = 0; slot < PaletteSize; slot++) begin
      e = palette_color(slot);
      d = chan_gap({pix[15:11], 3'b000}, {e[15:11], 3'b000})
        + chan_gap({pix[10:5], 2'b00}, {e[10:5], 2'b00})
        + chan_gap({pix[4:0], 3'b000}, {e[4:0], 3'b000});
      if (d < best_d) begin
        best_d = d;
        best   = idx_t'(slot);
      end
    end
    return best;
  endfunction

  // half random colors, some exact palette hits, some near misses
  function automatic color_t pick_pixel();
    color_t      base;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    base = palette_color($urandom_range(0, PaletteSize - 1));
    if (kind < 5) return color_t'($urandom);
    if (kind < 7) return base;
    return base ^ color_t'($urandom & 32'h1863);
  endfunction

  task automatic send_pair(color_t first, color_t second);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 3);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second, first};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_bytes_q.push_back({closest_entry(first), closest_entry(second)});
    pairs_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  task automatic load_palette(input reg_t words [NumRegs]);
    wait_idle();
    for (int k = 0; k < NumRegs; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= RegIdxW'(k);
      cfg_wdata_i <= words[k];
      @(posedge clk_i);
      palette_q[k] = words[k];
    end
    cfg_we_i <= 1'b0;
    palettes_loaded++;
  endtask

  task automatic test_reset_palette();
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    for (int unsigned slot = 0; slot < PaletteSize; slot += 2) begin
      send_pair(palette_color(slot), palette_color(slot + 1));
    end
    send_pair(16'h7BEF, 16'h0821);
    send_pair(16'h5555, 16'hAAAA);
  endtask

  task automatic test_tie_break();
    reg_t words [NumRegs];
    foreach (words[k]) words[k] = '1;
    load_palette(words);
    send_pair(16'h8410, 16'h0000);
    // entries 6 and 9 sit at equal distance from mid gray
    words[3] = {16'hFFFF, 16'h8C10};
    words[4] = {16'h7C10, 16'hFFFF};
    load_palette(words);
    send_pair(16'h8410, 16'h8410);
    send_pair(16'hFFFF, 16'h8410);
    words[3] = {16'hFFFF, 16'h7C10};
    words[4] = {16'h8C10, 16'hFFFF};
    load_palette(words);
    send_pair(16'h8410, 16'h8411);
  endtask

  task automatic test_register_extremes();
    reg_t words [NumRegs];
    foreach (words[k]) words[k] = '0;
    load_palette(words);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hF81F, 16'h07E0);
    foreach (words[k]) words[k] = '1;
    load_palette(words);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hF81F, 16'h07E0);
  endtask

  task automatic test_random_traffic();
    reg_t   words [NumRegs];
    color_t seeds [4];
    for (int phase = 0; phase < RandPhases; phase++) begin
      foreach (seeds[j]) seeds[j] = color_t'($urandom);
      for (int k = 0; k < NumRegs; k++) begin
        case (phase % 3)
          0: words[k] = reg_t'($urandom);
          // few distinct colors, lots of exact ties
          1: words[k] = {seeds[$urandom_range(0, 3)], seeds[$urandom_range(0, 3)]};
          // tight cluster around one color
          default: words[k] = {seeds[0] ^ color_t'($urandom & 32'h1863),
                               seeds[0] ^ color_t'($urandom & 32'h1863)};
        endcase
      end
      load_palette(words);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 3 && n == PhaseItems / 2) wait_idle();
        send_pair(pick_pixel(), pick_pixel());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes_q.size() == 0) begin
        $error("packed_indices: no item expected, actual %02h", m_axis_tdata);
        mismatches++;
      end else begin
        want_byte = expected_bytes_q.pop_front();
        if (m_axis_tdata !== want_byte) begin
          $error("packed_indices: expected %02h, actual %02h", want_byte, m_axis_tdata);
          mismatches++;
        end
        bytes_checked++;
      end
    end
    if (stall_hold == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_hold = $urandom_range(50, 300);
    end
    stall_hold--;
    case (stall_mode)
      StallNone:   m_axis_tready <= 1'b1;
      StallRandom: m_axis_tready <= ($urandom_range(0, 3) != 0);
      StallDuty:   m_axis_tready <= (stall_hold % 5) < 2;
      default:     m_axis_tready <= ($urandom_range(0, 9) == 0) ? !m_axis_tready : m_axis_tready;
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    palette_q = PalReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_palette();
    test_tie_break();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("sent %0d pixel pairs, checked %0d packed bytes over %0d palette loads",
             pairs_sent, bytes_checked, palettes_loaded);
    $display("corners, tie breaks, register extremes and bursty random traffic with stalls");
    if (mismatches == 0 && expected_bytes_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
